FILE: rtl/core/cpqm_pkg.sv
package cpqm_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 53;

    // register indexes, byte address = 4 * index
    localparam logic [2:0] REG_ANGLE_KP       = 3'd0;
    localparam logic [2:0] REG_ANGLE_KI       = 3'd1;
    localparam logic [2:0] REG_ANGLE_KD       = 3'd2;
    localparam logic [2:0] REG_RATE_KP        = 3'd3;
    localparam logic [2:0] REG_RATE_KI        = 3'd4;
    localparam logic [2:0] REG_RATE_KD        = 3'd5;
    localparam logic [2:0] REG_YAW_ANGLE_KP   = 3'd6;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd7;

    localparam logic [15:0] RST_KP    = 16'd2560;
    localparam logic [15:0] RST_KI    = 16'd0;
    localparam logic [15:0] RST_KD    = 16'd0;
    localparam logic [22:0] RST_LIMIT = 23'd25600;

    typedef struct packed {
        logic [15:0] angle_kp;
        logic [15:0] angle_ki;
        logic [15:0] angle_kd;
        logic [15:0] rate_kp;
        logic [15:0] rate_ki;
        logic [15:0] rate_kd;
        logic [15:0] yaw_angle_kp;
        logic [22:0] integral_limit;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic               acc;
        logic signed [33:0] op_a;
        logic signed [18:0] op_b;
    } mac_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [3:0][15:0] motor;
    } res_t;

endpackage

FILE: rtl/core/cpqm_in_if.sv
interface cpqm_in_if;
    logic               valid;
    logic               ready;
    logic [11:0]        stick_roll;
    logic [11:0]        stick_pitch;
    logic [11:0]        stick_yaw;
    logic [11:0]        stick_throttle;
    logic signed [16:0] roll_angle;
    logic signed [16:0] pitch_angle;
    logic signed [19:0] gyro_x;
    logic signed [19:0] gyro_y;
    logic signed [19:0] gyro_z;
    logic signed [13:0] height_correction;
    logic [1:0]         flight_mode;
    logic               armed;

    modport source (
        output valid, stick_roll, stick_pitch, stick_yaw, stick_throttle, roll_angle,
               pitch_angle, gyro_x, gyro_y, gyro_z, height_correction, flight_mode, armed,
        input  ready
    );
    modport sink (
        input  valid, stick_roll, stick_pitch, stick_yaw, stick_throttle, roll_angle,
               pitch_angle, gyro_x, gyro_y, gyro_z, height_correction, flight_mode, armed,
        output ready
    );
endinterface

FILE: rtl/core/cpqm_out_if.sv
interface cpqm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] motor_front_right;
    logic [15:0] motor_front_left;
    logic [15:0] motor_rear_left;
    logic [15:0] motor_rear_right;

    modport source (
        output valid, motor_front_right, motor_front_left, motor_rear_left, motor_rear_right,
        input  ready
    );
    modport sink (
        input  valid, motor_front_right, motor_front_left, motor_rear_left, motor_rear_right,
        output ready
    );
endinterface

FILE: rtl/core/cpqm_regs.sv
module cpqm_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpqm_pkg::ADDR_W-1:0] paddr,
    input  logic [cpqm_pkg::DATA_W-1:0] pwdata,
    output logic [cpqm_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output cpqm_pkg::cfg_t              cfg
);
    import cpqm_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_kp       <= RST_KP;
            cfg_reg.angle_ki       <= RST_KI;
            cfg_reg.angle_kd       <= RST_KD;
            cfg_reg.rate_kp        <= RST_KP;
            cfg_reg.rate_ki        <= RST_KI;
            cfg_reg.rate_kd        <= RST_KD;
            cfg_reg.yaw_angle_kp   <= RST_KP;
            cfg_reg.integral_limit <= RST_LIMIT;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ANGLE_KP:       cfg_reg.angle_kp       <= pwdata[15:0];
                REG_ANGLE_KI:       cfg_reg.angle_ki       <= pwdata[15:0];
                REG_ANGLE_KD:       cfg_reg.angle_kd       <= pwdata[15:0];
                REG_RATE_KP:        cfg_reg.rate_kp        <= pwdata[15:0];
                REG_RATE_KI:        cfg_reg.rate_ki        <= pwdata[15:0];
                REG_RATE_KD:        cfg_reg.rate_kd        <= pwdata[15:0];
                REG_YAW_ANGLE_KP:   cfg_reg.yaw_angle_kp   <= pwdata[15:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ANGLE_KP:       prdata = {16'd0, cfg_reg.angle_kp};
            REG_ANGLE_KI:       prdata = {16'd0, cfg_reg.angle_ki};
            REG_ANGLE_KD:       prdata = {16'd0, cfg_reg.angle_kd};
            REG_RATE_KP:        prdata = {16'd0, cfg_reg.rate_kp};
            REG_RATE_KI:        prdata = {16'd0, cfg_reg.rate_ki};
            REG_RATE_KD:        prdata = {16'd0, cfg_reg.rate_kd};
            REG_YAW_ANGLE_KP:   prdata = {16'd0, cfg_reg.yaw_angle_kp};
            REG_INTEGRAL_LIMIT: prdata = {9'd0, cfg_reg.integral_limit};
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/cpqm_mac.sv
module cpqm_mac (
    input  logic                               clk,
    input  cpqm_pkg::mac_ctl_t                 ctl,
    output logic signed [cpqm_pkg::ACC_W-1:0]  acc
);
    import cpqm_pkg::*;

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_reg;

    assign prod = ctl.op_a * ctl.op_b;
    assign acc  = acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            acc_reg <= prod;
        else if (ctl.acc)
            acc_reg <= acc_reg + prod;
    end

endmodule

FILE: rtl/core/cpqm_core.sv
module cpqm_core (
    input  logic           clk,
    input  logic           rst_n,
    input  cpqm_pkg::cfg_t cfg,
    cpqm_in_if.sink        tick,
    input  logic           out_free,
    output cpqm_pkg::res_t res
);
    import cpqm_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_SP_MUL  = 10'b0000000010,
        ST_SP_WB   = 10'b0000000100,
        ST_YAW_MUL = 10'b0000001000,
        ST_YAW_WB  = 10'b0000010000,
        ST_PID_ERR = 10'b0000100000,
        ST_PID_MUL = 10'b0001000000,
        ST_PID_WB  = 10'b0010000000,
        ST_MIX     = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic [11:0]        stick_roll;
        logic [11:0]        stick_pitch;
        logic [11:0]        stick_yaw;
        logic [11:0]        stick_throttle;
        logic signed [16:0] roll_angle;
        logic signed [16:0] pitch_angle;
        logic signed [19:0] gyro_x;
        logic signed [19:0] gyro_y;
        logic signed [19:0] gyro_z;
        logic signed [13:0] height_correction;
        logic [1:0]         flight_mode;
        logic               armed;
    } tick_t;

    localparam logic [2:0] PID_ROLL_ANG  = 3'd0;
    localparam logic [2:0] PID_PITCH_ANG = 3'd1;
    localparam logic [2:0] PID_ROLL_RATE = 3'd2;
    localparam logic [2:0] PID_PITCH_RT  = 3'd3;
    localparam logic [2:0] PID_YAW_RATE  = 3'd4;

    localparam logic [1:0] SP_LAST    = 2'd2;
    localparam logic [1:0] TERM_LAST  = 2'd2;
    localparam logic [1:0] MOTOR_LAST = 2'd3;
    localparam logic [1:0] MODE_HEIGHT = 2'd2;

    localparam logic signed [12:0] STICK_MID = 13'sd1500;
    localparam logic signed [12:0] THR_BASE  = 13'sd1000;
    localparam logic [11:0]        THR_CUT   = 12'd1050;
    localparam logic signed [26:0] DUTY_MAX  = 27'sd16383;
    // ceil(2^20 / 3); exact for magnitudes below 2^18
    localparam logic [33:0]        RECIP3    = 34'd349526;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat45(input logic signed [44:0] v);
        if (v[44:31] != {14{v[31]}})
            return v[44] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [1:0]              cnt_reg;
    logic [2:0]              pid_reg;
    tick_t                   in_reg;
    logic signed [16:0]      sp_reg [3];
    logic signed [24:0]      ysp_reg;
    logic signed [31:0]      e_reg;
    logic signed [23:0]      i_reg;
    logic signed [32:0]      d_reg;
    logic signed [23:0]      integ_reg [5];
    logic signed [31:0]      prev_reg [5];
    logic signed [31:0]      pid_out_reg [5];
    logic [3:0][15:0]        duty_reg;

    mac_ctl_t                mac_ctl;
    logic signed [ACC_W-1:0] acc;

    cpqm_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .acc (acc)
    );

    // setpoint: (pulse - 1500) * 64 / 3, toward zero, via reciprocal on the magnitude
    logic [11:0]        pulse;
    logic signed [12:0] sp_dx;
    logic signed [18:0] sp_x64;
    logic [17:0]        sp_mag;
    logic [15:0]        sp_q;
    logic signed [16:0] sp_val;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    pulse = in_reg.stick_roll;
            2'd1:    pulse = in_reg.stick_pitch;
            default: pulse = in_reg.stick_yaw;
        endcase
    end

    assign sp_dx  = $signed({1'b0, pulse}) - STICK_MID;
    assign sp_x64 = $signed({sp_dx, 6'b0});
    assign sp_mag = sp_x64[18] ? 18'(-sp_x64) : sp_x64[17:0];
    assign sp_q   = acc[35:20];
    assign sp_val = sp_x64[18] ? -$signed({1'b0, sp_q}) : $signed({1'b0, sp_q});

    // PID error, integral and difference
    logic signed [32:0] err_raw;
    logic signed [31:0] err;
    logic signed [33:0] isum;
    logic signed [33:0] lim;
    logic signed [33:0] lim_neg;
    logic signed [23:0] i_new;
    logic signed [32:0] d_new;
    logic               angle_stage;
    logic [15:0]        gain_p, gain_i, gain_d;

    always_comb
    begin
        case (pid_reg)
            PID_ROLL_ANG:  err_raw = 33'(sp_reg[0]) + 33'(in_reg.roll_angle);
            PID_PITCH_ANG: err_raw = 33'(sp_reg[1]) - 33'(in_reg.pitch_angle);
            PID_ROLL_RATE: err_raw = 33'(pid_out_reg[0]) + 33'(in_reg.gyro_x);
            PID_PITCH_RT:  err_raw = 33'(pid_out_reg[1]) + 33'(in_reg.gyro_y);
            default:       err_raw = 33'(ysp_reg) + 33'(in_reg.gyro_z);
        endcase
    end

    assign err     = sat33(err_raw);
    assign isum    = 34'(integ_reg[pid_reg]) + 34'(err);
    assign lim     = $signed({11'b0, cfg.integral_limit});
    assign lim_neg = -lim;
    assign d_new   = 33'(err) - 33'(prev_reg[pid_reg]);

    always_comb
    begin
        if (isum > lim)
            i_new = lim[23:0];
        else if (isum < lim_neg)
            i_new = lim_neg[23:0];
        else
            i_new = isum[23:0];
    end

    assign angle_stage = (pid_reg == PID_ROLL_ANG) || (pid_reg == PID_PITCH_ANG);
    assign gain_p = angle_stage ? cfg.angle_kp : cfg.rate_kp;
    assign gain_i = angle_stage ? cfg.angle_ki : cfg.rate_ki;
    assign gain_d = angle_stage ? cfg.angle_kd : cfg.rate_kd;

    always_comb
    begin
        mac_ctl = '0;
        case (state_reg)
            ST_SP_MUL:
            begin
                mac_ctl.load = 1'b1;
                mac_ctl.op_a = RECIP3;
                mac_ctl.op_b = {1'b0, sp_mag};
            end
            ST_YAW_MUL:
            begin
                mac_ctl.load = 1'b1;
                mac_ctl.op_a = 34'(sp_reg[2]);
                mac_ctl.op_b = {3'b0, cfg.yaw_angle_kp};
            end
            ST_PID_MUL:
            begin
                case (cnt_reg)
                    2'd0:
                    begin
                        mac_ctl.load = 1'b1;
                        mac_ctl.op_a = 34'(e_reg);
                        mac_ctl.op_b = {3'b0, gain_p};
                    end
                    2'd1:
                    begin
                        mac_ctl.acc  = 1'b1;
                        mac_ctl.op_a = 34'(i_reg);
                        mac_ctl.op_b = {3'b0, gain_i};
                    end
                    default:
                    begin
                        mac_ctl.acc  = 1'b1;
                        mac_ctl.op_a = 34'(d_reg);
                        mac_ctl.op_b = {3'b0, gain_d};
                    end
                endcase
            end
            default: ;
        endcase
    end

    // mixer, one motor per cycle
    logic               thr_ok;
    logic signed [14:0] base;
    logic signed [34:0] s35, ty, tr, tp, mix_sum;
    logic signed [26:0] duty27;
    logic [13:0]        duty14;

    assign thr_ok = in_reg.stick_throttle > THR_CUT;
    assign base   = 15'($signed({1'b0, in_reg.stick_throttle}) - THR_BASE)
                  + ((in_reg.flight_mode == MODE_HEIGHT) ? 15'(in_reg.height_correction)
                                                         : 15'sd0);
    assign s35    = 35'($signed({base, 8'b0}));
    assign ty     = 35'(pid_out_reg[4]);
    assign tr     = 35'(pid_out_reg[2]);
    assign tp     = 35'(pid_out_reg[3]);

    always_comb
    begin
        case (cnt_reg)
            2'd0:    mix_sum = s35 + ty - tr - tp;
            2'd1:    mix_sum = s35 - ty + tr - tp;
            2'd2:    mix_sum = s35 + ty + tr + tp;
            default: mix_sum = s35 - ty - tr + tp;
        endcase
    end

    assign duty27 = mix_sum[34:8];

    always_comb
    begin
        if (!thr_ok || !in_reg.armed || duty27 <= 27'sd0)
            duty14 = '0;
        else if (duty27 > DUTY_MAX)
            duty14 = DUTY_MAX[13:0];
        else
            duty14 = duty27[13:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (tick.valid) state_next = ST_SP_MUL;
            ST_SP_MUL:  state_next = ST_SP_WB;
            ST_SP_WB:   state_next = (cnt_reg == SP_LAST) ? ST_YAW_MUL : ST_SP_MUL;
            ST_YAW_MUL: state_next = ST_YAW_WB;
            ST_YAW_WB:  state_next = ST_PID_ERR;
            ST_PID_ERR: state_next = ST_PID_MUL;
            ST_PID_MUL: if (cnt_reg == TERM_LAST) state_next = ST_PID_WB;
            ST_PID_WB:  state_next = (pid_reg == PID_YAW_RATE) ? ST_MIX : ST_PID_ERR;
            ST_MIX:     if (cnt_reg == MOTOR_LAST) state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    assign tick.ready = (state_reg == ST_IDLE);
    assign res.valid  = (state_reg == ST_DONE);
    assign res.motor  = duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pid_reg   <= PID_ROLL_ANG;
            for (int k = 0; k < 5; k++)
            begin
                integ_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    pid_reg <= PID_ROLL_ANG;
                end
                ST_SP_WB:   cnt_reg <= (cnt_reg == SP_LAST) ? 2'd0 : cnt_reg + 2'd1;
                ST_PID_ERR:
                begin
                    cnt_reg            <= '0;
                    integ_reg[pid_reg] <= i_new;
                    prev_reg[pid_reg]  <= err;
                end
                ST_PID_MUL: cnt_reg <= (cnt_reg == TERM_LAST) ? 2'd0 : cnt_reg + 2'd1;
                ST_PID_WB:  pid_reg <= pid_reg + 3'd1;
                ST_MIX:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    // low throttle drops the roll and pitch integrators, yaw keeps its own
                    if (cnt_reg == 2'd0 && !thr_ok)
                    begin
                        for (int k = 0; k < 4; k++)
                            integ_reg[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    in_reg.stick_roll        <= tick.stick_roll;
                    in_reg.stick_pitch       <= tick.stick_pitch;
                    in_reg.stick_yaw         <= tick.stick_yaw;
                    in_reg.stick_throttle    <= tick.stick_throttle;
                    in_reg.roll_angle        <= tick.roll_angle;
                    in_reg.pitch_angle       <= tick.pitch_angle;
                    in_reg.gyro_x            <= tick.gyro_x;
                    in_reg.gyro_y            <= tick.gyro_y;
                    in_reg.gyro_z            <= tick.gyro_z;
                    in_reg.height_correction <= tick.height_correction;
                    in_reg.flight_mode       <= tick.flight_mode;
                    in_reg.armed             <= tick.armed;
                end
            end
            ST_SP_WB:  sp_reg[cnt_reg] <= sp_val;
            ST_YAW_WB: ysp_reg <= acc[32:8];
            ST_PID_ERR:
            begin
                e_reg <= err;
                i_reg <= i_new;
                d_reg <= d_new;
            end
            ST_PID_WB: pid_out_reg[pid_reg] <= sat45(acc[52:8]);
            ST_MIX:    duty_reg[cnt_reg] <= {duty14, 2'b00};
            default: ;
        endcase
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PID_MUL) |-> (34'(i_reg) <= lim && 34'(i_reg) >= lim_neg))
        else $error("integral outside limit");

    a_pid_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PID_ERR || state_reg == ST_PID_MUL || state_reg == ST_PID_WB)
        |-> (pid_reg <= PID_YAW_RATE))
        else $error("PID index out of range");

    a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !in_reg.armed) |-> (duty_reg == '0))
        else $error("nonzero duty while disarmed");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (state_reg == ST_IDLE))
        else $error("result not released after handoff");

endmodule

FILE: rtl/core/cascaded_pid_quad_mixer.sv
// Cascaded PID attitude controller with an X quad mixer. One tick transaction is taken
// when the block is idle and yields one motor transaction; no new tick is taken until
// the result has moved into the output register and the block is idle again. The work
// is sequenced on the single shared 34x19 multiply-accumulate unit: three setpoint
// reciprocal multiplies and the yaw setpoint gain (a multiply and a write-back each),
// five PID stages (error/integral update, three gain terms, round and saturate), and the
// mixer working one motor per cycle. Gains and the integral limit sit behind an APB
// register port with zero wait states and should only be written while no tick is in
// flight.
module cascaded_pid_quad_mixer (
    input  logic                        clk,
    input  logic                        rst_n,
    cpqm_in_if.sink                     tick,
    cpqm_out_if.source                  motors,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpqm_pkg::ADDR_W-1:0] paddr,
    input  logic [cpqm_pkg::DATA_W-1:0] pwdata,
    output logic [cpqm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import cpqm_pkg::*;

    cfg_t             cfg;
    res_t             res;
    logic             out_free;
    logic             out_valid_reg;
    logic [3:0][15:0] motor_reg;

    cpqm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpqm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .tick     (tick),
        .out_free (out_free),
        .res      (res)
    );

    // output register frees up in the same cycle it is taken
    assign out_free = !out_valid_reg || motors.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res.valid && out_free)
            out_valid_reg <= 1'b1;
        else if (motors.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
            motor_reg <= res.motor;
    end

    assign motors.valid             = out_valid_reg;
    assign motors.motor_front_right = motor_reg[0];
    assign motors.motor_front_left  = motor_reg[1];
    assign motors.motor_rear_left   = motor_reg[2];
    assign motors.motor_rear_right  = motor_reg[3];

    a_duty_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (motor_reg[0][1:0] == 2'b00 && motor_reg[1][1:0] == 2'b00
                        && motor_reg[2][1:0] == 2'b00 && motor_reg[3][1:0] == 2'b00))
        else $error("motor value not a multiple of four");

endmodule

FILE: verif/cpqm_tb_pkg.sv
package cpqm_tb_pkg;

    typedef struct {
        logic [11:0]        stick_roll;
        logic [11:0]        stick_pitch;
        logic [11:0]        stick_yaw;
        logic [11:0]        stick_throttle;
        logic signed [16:0] roll_angle;
        logic signed [16:0] pitch_angle;
        logic signed [19:0] gyro_x;
        logic signed [19:0] gyro_y;
        logic signed [19:0] gyro_z;
        logic signed [13:0] height_correction;
        logic [1:0]         flight_mode;
        logic               armed;
    } tick_t;

    typedef struct {
        logic [15:0] front_right;
        logic [15:0] front_left;
        logic [15:0] rear_left;
        logic [15:0] rear_right;
    } duty_t;

    localparam logic [1:0] MODE_ATT0   = 2'd0;
    localparam logic [1:0] MODE_ATT1   = 2'd1;
    localparam logic [1:0] MODE_HEIGHT = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

endpackage

FILE: verif/tb.sv
module tb;
    import cpqm_pkg::*;
    import cpqm_tb_pkg::*;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    cpqm_in_if  tick_ch ();
    cpqm_out_if motor_ch ();

    cascaded_pid_quad_mixer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch.sink),
        .motors  (motor_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers and loop state
    longint g_akp, g_aki, g_akd, g_rkp, g_rki, g_rkd, g_ykp, g_lim;
    longint integ_st [5];
    longint prev_st [5];

    duty_t duty_q [$];
    int    fail_cnt;
    bit    rx_long_stalls;

    initial begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial begin
        #200000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint fdiv256(longint v);
        if (v >= 0)
            return v >>> 8;
        return -((-v + 255) >>> 8);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint stick_sp(logic [11:0] pulse);
        longint d;
        d = longint'(pulse) - 1500;
        return (d * 64) / 3;
    endfunction

    function automatic longint pid_run(int idx, longint e, longint kp, longint ki, longint kd);
        longint i;
        longint d;
        i = integ_st[idx] + e;
        d = e - prev_st[idx];
        if (i > g_lim)
            i = g_lim;
        if (i < -g_lim)
            i = -g_lim;
        integ_st[idx] = i;
        prev_st[idx] = e;
        return sat32(fdiv256(kp * e + ki * i + kd * d));
    endfunction

    function automatic logic [15:0] to_duty(longint s);
        longint d;
        d = fdiv256(s);
        if (d <= 0)
            d = 0;
        if (d > 16383)
            d = 16383;
        return 16'(d * 4);
    endfunction

    function automatic duty_t mix_tick(tick_t t);
        longint ra, pa, ysp, r, p, y, s;
        duty_t o;
        ra  = pid_run(0, stick_sp(t.stick_roll) + t.roll_angle, g_akp, g_aki, g_akd);
        pa  = pid_run(1, stick_sp(t.stick_pitch) - t.pitch_angle, g_akp, g_aki, g_akd);
        ysp = fdiv256(g_ykp * stick_sp(t.stick_yaw));
        r   = pid_run(2, sat32(ra + t.gyro_x), g_rkp, g_rki, g_rkd);
        p   = pid_run(3, sat32(pa + t.gyro_y), g_rkp, g_rki, g_rkd);
        y   = pid_run(4, sat32(ysp + t.gyro_z), g_rkp, g_rki, g_rkd);
        o = '{16'd0, 16'd0, 16'd0, 16'd0};
        if (t.stick_throttle > 1050)
        begin
            s = (longint'(t.stick_throttle) - 1000) * 256;
            if (t.flight_mode == MODE_HEIGHT)
                s += longint'(t.height_correction) * 256;
            if (t.armed)
            begin
                o.front_right = to_duty(s + y - r - p);
                o.front_left  = to_duty(s - y + r - p);
                o.rear_left   = to_duty(s + y + r + p);
                o.rear_right  = to_duty(s - y - r + p);
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                integ_st[k] = 0;
        end
        return o;
    endfunction

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // the bus is left selected between writes; set_gains releases it after the last one
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_ANGLE_KP:     g_akp = val[15:0];
            REG_ANGLE_KI:     g_aki = val[15:0];
            REG_ANGLE_KD:     g_akd = val[15:0];
            REG_RATE_KP:      g_rkp = val[15:0];
            REG_RATE_KI:      g_rki = val[15:0];
            REG_RATE_KD:      g_rkd = val[15:0];
            REG_YAW_ANGLE_KP: g_ykp = val[15:0];
            default:          g_lim = val[22:0];
        endcase
    endtask

    task automatic set_gains(logic [15:0] akp, logic [15:0] aki, logic [15:0] akd,
                             logic [15:0] rkp, logic [15:0] rki, logic [15:0] rkd,
                             logic [15:0] ykp, logic [22:0] lim);
        write_reg(REG_ANGLE_KP, 32'(akp));
        write_reg(REG_ANGLE_KI, 32'(aki));
        write_reg(REG_ANGLE_KD, 32'(akd));
        write_reg(REG_RATE_KP, 32'(rkp));
        write_reg(REG_RATE_KI, 32'(rki));
        write_reg(REG_RATE_KD, 32'(rkd));
        write_reg(REG_YAW_ANGLE_KP, 32'(ykp));
        write_reg(REG_INTEGRAL_LIMIT, 32'(lim));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // valid stays up after an accept only when the next transaction follows at once
    task automatic send_tick(tick_t t);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
        tick_ch.valid             <= 1'b1;
        tick_ch.stick_roll        <= t.stick_roll;
        tick_ch.stick_pitch       <= t.stick_pitch;
        tick_ch.stick_yaw         <= t.stick_yaw;
        tick_ch.stick_throttle    <= t.stick_throttle;
        tick_ch.roll_angle        <= t.roll_angle;
        tick_ch.pitch_angle       <= t.pitch_angle;
        tick_ch.gyro_x            <= t.gyro_x;
        tick_ch.gyro_y            <= t.gyro_y;
        tick_ch.gyro_z            <= t.gyro_z;
        tick_ch.height_correction <= t.height_correction;
        tick_ch.flight_mode       <= t.flight_mode;
        tick_ch.armed             <= t.armed;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        duty_q.push_back(mix_tick(t));
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (duty_q.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
    endtask

    function automatic tick_t rand_tick(bit wild);
        tick_t t;
        if (wild)
        begin
            t.stick_roll     = 12'($urandom);
            t.stick_pitch    = 12'($urandom);
            t.stick_yaw      = 12'($urandom);
            t.stick_throttle = 12'($urandom);
            t.roll_angle     = 17'($urandom);
            t.pitch_angle    = 17'($urandom);
            t.gyro_x         = 20'($urandom);
            t.gyro_y         = 20'($urandom);
            t.gyro_z         = 20'($urandom);
        end
        else
        begin
            t.stick_roll     = 12'($urandom_range(1000, 2000));
            t.stick_pitch    = 12'($urandom_range(1000, 2000));
            t.stick_yaw      = 12'($urandom_range(1000, 2000));
            t.stick_throttle = 12'($urandom_range(1000, 2000));
            t.roll_angle     = 17'($urandom_range(0, 92160) - 46080);
            t.pitch_angle    = 17'($urandom_range(0, 92160) - 46080);
            t.gyro_x         = 20'($urandom_range(0, 40000) - 20000);
            t.gyro_y         = 20'($urandom_range(0, 40000) - 20000);
            t.gyro_z         = 20'($urandom_range(0, 40000) - 20000);
        end
        t.height_correction = 14'($urandom);
        t.flight_mode       = 2'($urandom);
        t.armed             = ($urandom_range(0, 9) != 0);
        return t;
    endfunction

    function automatic tick_t mk(logic [11:0] sr, logic [11:0] sp, logic [11:0] sy,
                                 logic [11:0] thr, int ra, int pa, int gx, int gy, int gz,
                                 int hc, logic [1:0] md, logic arm);
        tick_t t;
        t = '{sr, sp, sy, thr, 17'(ra), 17'(pa), 20'(gx), 20'(gy), 20'(gz), 14'(hc), md, arm};
        return t;
    endfunction

    task automatic test_directed();
        send_tick(mk(1500, 1500, 1500, 1500, 0, 0, 0, 0, 0, 0, MODE_ATT0, 1'b1));
        send_tick(mk(2000, 1000, 1800, 1600, 2560, -2560, 100, -100, 50, 0, MODE_ATT1, 1'b1));
        send_tick(mk(1500, 1500, 1500, 1050, 0, 0, 0, 0, 0, 0, MODE_ATT0, 1'b1));
        send_tick(mk(1500, 1500, 1500, 1051, 0, 0, 0, 0, 0, 0, MODE_ATT0, 1'b1));
        send_tick(mk(1600, 1400, 1500, 1700, 0, 0, 0, 0, 0, 0, MODE_ATT0, 1'b0));
        send_tick(mk(1500, 1500, 1500, 1500, 0, 0, 0, 0, 0, 8191, MODE_HEIGHT, 1'b1));
        send_tick(mk(1500, 1500, 1500, 1500, 0, 0, 0, 0, 0, -8192, MODE_HEIGHT, 1'b1));
        send_tick(mk(1500, 1500, 1500, 1500, 0, 0, 0, 0, 0, 4000, MODE_SPARE, 1'b1));
        send_tick(mk(4095, 4095, 4095, 4095, 46080, 46080, 524287, 524287, 524287,
                     8191, MODE_HEIGHT, 1'b1));
        send_tick(mk(0, 0, 0, 0, -46080, -46080, -524288, -524288, -524288,
                     -8192, MODE_HEIGHT, 1'b1));
        send_tick(mk(0, 4095, 0, 4095, -65536, 65535, -524288, 524287, 0, 0,
                     MODE_ATT0, 1'b1));
        send_tick(mk(4095, 0, 4095, 3000, 65535, -65536, 524287, -524288, 0, 0,
                     MODE_ATT1, 1'b1));
        send_tick(mk(1500, 1500, 1500, 1000, 1000, 1000, 0, 0, 0, 0, MODE_ATT0, 1'b0));
        drain();
    endtask

    task automatic test_gain_extremes();
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  23'h7FFFFF);
        send_tick(mk(4095, 0, 4095, 4095, 65535, -65536, 524287, -524288, 524287, 0,
                     MODE_ATT0, 1'b1));
        send_tick(mk(0, 4095, 0, 4095, -65536, 65535, -524288, 524287, -524288, 0,
                     MODE_ATT0, 1'b1));
        send_tick(mk(1500, 1500, 1500, 1800, 0, 0, 0, 0, 0, 0, MODE_ATT0, 1'b1));
        drain();
        set_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 23'd0);
        send_tick(mk(2000, 1000, 1800, 1600, 2560, -2560, 100, -100, 50, 0, MODE_ATT0, 1'b1));
        send_tick(mk(1500, 1500, 1500, 1600, 0, 0, 0, 0, 0, -100, MODE_HEIGHT, 1'b1));
        drain();
    endtask

    task automatic test_random(int n);
        tick_t t;
        for (int i = 0; i < n; i++)
        begin
            t = rand_tick($urandom_range(0, 4) == 0);
            send_tick(t);
        end
        drain();
    endtask

    task automatic test_random_gains();
        for (int ph = 0; ph < 4; ph++)
        begin
            set_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 256)),
                      16'($urandom_range(0, 512)), 16'($urandom_range(0, 1024)),
                      16'($urandom_range(0, 256)), 16'($urandom_range(0, 512)),
                      16'($urandom_range(0, 2048)), 23'($urandom_range(0, 60000)));
            rx_long_stalls = (ph % 2 == 1);
            test_random(200);
        end
        rx_long_stalls = 1'b0;
    endtask

    // output side: random ready, scoreboard compare
    initial begin
        int g;
        duty_t exp_d;
        motor_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = rx_long_stalls ? gap_len() : (($urandom_range(0, 3) == 0) ? gap_len() : 0);
            motor_ch.ready <= (g == 0);
            if (g != 0)
            begin
                repeat (g)
                    @(posedge clk);
                motor_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (motor_ch.valid && motor_ch.ready)
            begin
                if (duty_q.size() == 0)
                begin
                    $error("motor transaction with nothing expected");
                    fail_cnt++;
                end
                else
                begin
                    exp_d = duty_q.pop_front();
                    if (motor_ch.motor_front_right !== exp_d.front_right)
                    begin
                        $error("motor_front_right exp %0d got %0d", exp_d.front_right,
                               motor_ch.motor_front_right);
                        fail_cnt++;
                    end
                    if (motor_ch.motor_front_left !== exp_d.front_left)
                    begin
                        $error("motor_front_left exp %0d got %0d", exp_d.front_left,
                               motor_ch.motor_front_left);
                        fail_cnt++;
                    end
                    if (motor_ch.motor_rear_left !== exp_d.rear_left)
                    begin
                        $error("motor_rear_left exp %0d got %0d", exp_d.rear_left,
                               motor_ch.motor_rear_left);
                        fail_cnt++;
                    end
                    if (motor_ch.motor_rear_right !== exp_d.rear_right)
                    begin
                        $error("motor_rear_right exp %0d got %0d", exp_d.rear_right,
                               motor_ch.motor_rear_right);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        fail_cnt = 0;
        rx_long_stalls = 1'b0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        tick_ch.valid             = 1'b0;
        tick_ch.stick_roll        = '0;
        tick_ch.stick_pitch       = '0;
        tick_ch.stick_yaw         = '0;
        tick_ch.stick_throttle    = '0;
        tick_ch.roll_angle        = '0;
        tick_ch.pitch_angle       = '0;
        tick_ch.gyro_x            = '0;
        tick_ch.gyro_y            = '0;
        tick_ch.gyro_z            = '0;
        tick_ch.height_correction = '0;
        tick_ch.flight_mode       = '0;
        tick_ch.armed             = 1'b0;
        g_akp = 2560; g_aki = 0; g_akd = 0;
        g_rkp = 2560; g_rki = 0; g_rkd = 0;
        g_ykp = 2560; g_lim = 25600;
        for (int k = 0; k < 5; k++)
        begin
            integ_st[k] = 0;
            prev_st[k] = 0;
        end
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_gain_extremes();
        test_random_gains();

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
